@@ design/srs_pkg.sv @@
package srs_pkg;

    localparam int unsigned OFF_W   = 48;
    localparam int unsigned LEN_W   = 32;
    localparam int unsigned SS_W    = 32;
    localparam int unsigned CNT_W   = 9;
    localparam int unsigned SRV_W   = 8;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned CFG_W   = 48;
    localparam int unsigned PC_W    = 3;
    localparam int unsigned DIV_STEPS = OFF_W;
    localparam int unsigned DCNT_W  = $clog2(DIV_STEPS);

    localparam int unsigned MAX_CHUNKS_DEF = 64;

    localparam logic [SS_W-1:0]  STRIPE_BYTES_RST  = SS_W'(65536);
    localparam logic [OFF_W-1:0] STRIPE_ORIGIN_RST = '0;
    localparam logic [CNT_W-1:0] SERVER_COUNT_RST  = CNT_W'(1);
    localparam logic [CNT_W-1:0] SERVER_COUNT_MAX  = CNT_W'(256);

    typedef enum logic [IDX_W-1:0] {
        REG_STRIPE_BYTES  = 2'd0,
        REG_STRIPE_ORIGIN = 2'd1,
        REG_SERVER_COUNT  = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BELOW = 2'd1,
        ST_MANY  = 2'd2
    } status_t;

    // Datapath operations selected by the control word.
    typedef enum logic [2:0] {
        OP_NOP       = 3'd0,
        OP_LOAD      = 3'd1,
        OP_SETUP     = 3'd2,
        OP_ERR_BELOW = 3'd3,
        OP_DIV       = 3'd4,
        OP_FIRST     = 3'd5,
        OP_CHECK     = 3'd6,
        OP_EMIT      = 3'd7
    } op_t;

    // Jump conditions; a taken jump loads the target, otherwise the step advances.
    typedef enum logic [2:0] {
        C_NEVER     = 3'd0,
        C_NO_INPUT  = 3'd1,
        C_ZERO_LEN  = 3'd2,
        C_ONE_SRV   = 3'd3,
        C_BELOW     = 3'd4,
        C_DIV_BUSY  = 3'd5,
        C_EMIT_MORE = 3'd6
    } cond_t;

    localparam logic [PC_W-1:0] STEP_WAIT  = 3'd0;
    localparam logic [PC_W-1:0] STEP_SETUP = 3'd1;
    localparam logic [PC_W-1:0] STEP_ONE   = 3'd2;
    localparam logic [PC_W-1:0] STEP_ORG   = 3'd3;
    localparam logic [PC_W-1:0] STEP_DIV   = 3'd4;
    localparam logic [PC_W-1:0] STEP_FIRST = 3'd5;
    localparam logic [PC_W-1:0] STEP_CHECK = 3'd6;
    localparam logic [PC_W-1:0] STEP_EMIT  = 3'd7;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic zero_len;
        logic one_srv;
        logic below;
        logic div_busy;
        logic emit_more;
    } flags_t;

    typedef struct packed {
        logic start;
        logic step;
    } div_ctrl_t;

    // The program. The emit step falls through to step 0 when the pointer wraps.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        case (pc)
            STEP_WAIT:  w = '{OP_LOAD,      C_NO_INPUT,  STEP_WAIT};
            STEP_SETUP: w = '{OP_SETUP,     C_ZERO_LEN,  STEP_WAIT};
            STEP_ONE:   w = '{OP_NOP,       C_ONE_SRV,   STEP_EMIT};
            STEP_ORG:   w = '{OP_ERR_BELOW, C_BELOW,     STEP_EMIT};
            STEP_DIV:   w = '{OP_DIV,       C_DIV_BUSY,  STEP_DIV};
            STEP_FIRST: w = '{OP_FIRST,     C_NEVER,     STEP_WAIT};
            STEP_CHECK: w = '{OP_CHECK,     C_NEVER,     STEP_WAIT};
            STEP_EMIT:  w = '{OP_EMIT,      C_EMIT_MORE, STEP_EMIT};
            default:    w = '{OP_NOP,       C_NEVER,     STEP_WAIT};
        endcase
        return w;
    endfunction

endpackage

@@ design/srs_ifs.sv @@
interface srs_region_if import srs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OFF_W-1:0] region_offset;
    logic [LEN_W-1:0] region_bytes;
    logic             access_kind;

    modport source (output valid, region_offset, region_bytes, access_kind, input ready);
    modport sink (input valid, region_offset, region_bytes, access_kind, output ready);
endinterface

interface srs_chunk_if import srs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SRV_W-1:0] server_index;
    logic [LEN_W-1:0] chunk_bytes;
    logic [LEN_W-1:0] buffer_offset;
    logic             chunk_kind;
    logic [1:0]       status;
    logic             last_chunk;

    modport source (output valid, server_index, chunk_bytes, buffer_offset, chunk_kind,
                    status, last_chunk, input ready);
    modport sink (input valid, server_index, chunk_bytes, buffer_offset, chunk_kind,
                  status, last_chunk, output ready);
endinterface

interface srs_cfg_if import srs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ design/stripe_region_splitter_core.sv @@
// Stripe region splitter.
// A region word (file offset, length, read or write kind) enters on the region
// channel; the block answers on the chunk channel with one word per stripe piece,
// giving the server, the piece length and its offset within the region buffer,
// with last_chunk set on the final word. An empty region gives no word at all.
// Errors (offset below the stripe origin, or more than MAX_CHUNKS pieces) give a
// single word with a non-zero status and last_chunk set.
// The cfg channel writes stripe_bytes (index 0), stripe_origin (1) and
// server_count (2); it is always ready and is to be used only while idle.
// The block handles one region at a time under a small microcoded
// sequencer. A striped region passes through the 48-step shared divider
// that finds the starting stripe and server before its pieces are emitted;
// single-server regions, empty regions and origin errors do not wait on it.
// Region ready is high only on the sequencer's wait step.
// The chunk output is one register deep: while it is stalled the sequencer
// holds on the emit step. Reset restores the register defaults (64 KiB stripes,
// origin 0, one server) and returns the sequencer to its wait step.
module stripe_region_splitter_core import srs_pkg::*;
#(
    parameter int unsigned MAX_CHUNKS = MAX_CHUNKS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    srs_region_if.sink   region,
    srs_chunk_if.source  chunk,
    srs_cfg_if.sink      cfg
);

    localparam int unsigned LIM_W = SS_W + $clog2(MAX_CHUNKS);
    localparam int unsigned SUM_W = LIM_W + 1;

    // Configuration registers.
    logic [SS_W-1:0]  stripe_bytes_reg;
    logic [OFF_W-1:0] stripe_origin_reg;
    logic [CNT_W-1:0] server_count_reg;

    // Region and walk state.
    logic [OFF_W-1:0] off_reg;
    logic [LEN_W-1:0] len_reg;
    logic             kind_reg;
    logic [LIM_W-1:0] lim_reg;
    logic [SS_W-1:0]  piece_reg;
    logic [LEN_W-1:0] done_reg;
    logic [SRV_W-1:0] srv_reg;
    status_t          status_reg;

    // Output register.
    logic             out_valid_reg;
    logic [SRV_W-1:0] out_srv_reg;
    logic [LEN_W-1:0] out_bytes_reg;
    logic [LEN_W-1:0] out_boff_reg;
    logic             out_kind_reg;
    status_t          out_status_reg;
    logic             out_last_reg;

    ctrl_t            ctrl;
    flags_t           flags;
    div_ctrl_t        dctl;

    logic [SS_W-1:0]  ss_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [SS_W-1:0]  div_rem;
    logic [SRV_W-1:0] div_mod;
    logic             div_busy;

    logic [LEN_W-1:0] left;
    logic             is_last;
    logic [LEN_W-1:0] piece_now;
    logic             slot_free;
    logic             emit_fire;
    logic             too_many;
    logic [CNT_W-1:0] srv_inc;

    // A zero stripe size counts as one byte; the server count is kept in 1..256.
    always_comb
    begin
        ss_eff = (stripe_bytes_reg == '0) ? SS_W'(1) : stripe_bytes_reg;
        if (server_count_reg == '0)
        begin
            cnt_eff = CNT_W'(1);
        end
        else if (server_count_reg > SERVER_COUNT_MAX)
        begin
            cnt_eff = SERVER_COUNT_MAX;
        end
        else
        begin
            cnt_eff = server_count_reg;
        end
    end

    // The current piece is cut short by what is left of the region, and that
    // also marks it as the last one.
    always_comb
    begin
        left      = len_reg - done_reg;
        is_last   = piece_reg >= left;
        piece_now = is_last ? left : piece_reg;
        slot_free = !out_valid_reg || chunk.ready;
        emit_fire = (ctrl.op == OP_EMIT) && slot_free;
        srv_inc   = {1'b0, srv_reg} + CNT_W'(1);
        // More than MAX_CHUNKS pieces exactly when the length passes the first
        // piece plus MAX_CHUNKS - 1 whole stripes.
        too_many  = SUM_W'(len_reg) > (SUM_W'(piece_reg) + SUM_W'(lim_reg));
    end

    assign flags.in_valid  = region.valid;
    assign flags.zero_len  = len_reg == '0;
    assign flags.one_srv   = cnt_eff == CNT_W'(1);
    assign flags.below     = off_reg < stripe_origin_reg;
    assign flags.div_busy  = div_busy;
    assign flags.emit_more = !slot_free || (status_reg == ST_OK && !is_last);

    assign dctl.start = ctrl.op == OP_SETUP;
    assign dctl.step  = ctrl.op == OP_DIV;

    assign region.ready = ctrl.op == OP_LOAD;
    assign cfg.ready    = 1'b1;

    srs_sequencer u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    srs_divider u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dctl      (dctl),
        .dividend  (off_reg - stripe_origin_reg),
        .divisor   (ss_eff),
        .modulus   (cnt_eff),
        .remainder (div_rem),
        .quo_mod   (div_mod),
        .busy      (div_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_bytes_reg  <= STRIPE_BYTES_RST;
            stripe_origin_reg <= STRIPE_ORIGIN_RST;
            server_count_reg  <= SERVER_COUNT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_STRIPE_BYTES:  stripe_bytes_reg  <= cfg.data[SS_W-1:0];
                REG_STRIPE_ORIGIN: stripe_origin_reg <= cfg.data[OFF_W-1:0];
                REG_SERVER_COUNT:  server_count_reg  <= cfg.data[CNT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chunk.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (ctrl.op)
                OP_SETUP:     status_reg <= ST_OK;
                OP_ERR_BELOW: status_reg <= ST_BELOW;
                OP_FIRST:     status_reg <= ST_OK;
                OP_CHECK:     status_reg <= too_many ? ST_MANY : ST_OK;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (ctrl.op)
            OP_LOAD:
            begin
                if (region.valid)
                begin
                    off_reg  <= region.region_offset;
                    len_reg  <= region.region_bytes;
                    kind_reg <= region.access_kind;
                end
            end
            OP_SETUP:
            begin
                // Single-server layout: the whole region from server 0.
                lim_reg   <= LIM_W'(ss_eff) * LIM_W'(MAX_CHUNKS - 1);
                piece_reg <= len_reg;
                done_reg  <= '0;
                srv_reg   <= '0;
            end
            OP_FIRST:
            begin
                piece_reg <= ss_eff - div_rem;
                srv_reg   <= div_mod;
            end
            OP_EMIT:
            begin
                if (slot_free)
                begin
                    out_kind_reg   <= kind_reg;
                    out_status_reg <= status_reg;
                    if (status_reg == ST_OK)
                    begin
                        out_srv_reg   <= srv_reg;
                        out_bytes_reg <= piece_now;
                        out_boff_reg  <= done_reg;
                        out_last_reg  <= is_last;
                        done_reg      <= done_reg + piece_now;
                        piece_reg     <= ss_eff;
                        srv_reg       <= (srv_inc == cnt_eff) ? '0 : srv_inc[SRV_W-1:0];
                    end
                    else
                    begin
                        out_srv_reg   <= '0;
                        out_bytes_reg <= '0;
                        out_boff_reg  <= '0;
                        out_last_reg  <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign chunk.valid         = out_valid_reg;
    assign chunk.server_index  = out_srv_reg;
    assign chunk.chunk_bytes   = out_bytes_reg;
    assign chunk.buffer_offset = out_boff_reg;
    assign chunk.chunk_kind    = out_kind_reg;
    assign chunk.status        = out_status_reg;
    assign chunk.last_chunk    = out_last_reg;

endmodule

@@ design/srs_sequencer.sv @@
module srs_sequencer import srs_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    ucode_t          word;
    logic            jump;

    assign word    = ucode_rom(pc_reg);
    assign ctrl.op = word.op;

    always_comb
    begin
        case (word.cond)
            C_NEVER:     jump = 1'b0;
            C_NO_INPUT:  jump = !flags.in_valid;
            C_ZERO_LEN:  jump = flags.zero_len;
            C_ONE_SRV:   jump = flags.one_srv;
            C_BELOW:     jump = flags.below;
            C_DIV_BUSY:  jump = flags.div_busy;
            C_EMIT_MORE: jump = flags.emit_more;
            default:     jump = 1'b0;
        endcase
        pc_next = jump ? word.target : pc_reg + PC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ design/srs_divider.sv @@
module srs_divider import srs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_ctrl_t        dctl,
    input  logic [OFF_W-1:0] dividend,
    input  logic [SS_W-1:0]  divisor,
    input  logic [CNT_W-1:0] modulus,
    output logic [SS_W-1:0]  remainder,
    output logic [SRV_W-1:0] quo_mod,
    output logic             busy
);

    // Restoring division, one quotient bit per step. Each quotient bit is also
    // folded into the quotient modulo the server count as it appears.
    logic [OFF_W-1:0]  dvd_reg;
    logic [SS_W-1:0]   rem_reg;
    logic [SRV_W-1:0]  mod_reg;
    logic [DCNT_W-1:0] count_reg;

    logic [SS_W:0]     trial;
    logic              qbit;
    logic [SS_W-1:0]   rem_next;
    logic [CNT_W-1:0]  mod_dbl;
    logic [SRV_W-1:0]  mod_next;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[OFF_W-1]};
        qbit     = trial >= {1'b0, divisor};
        rem_next = qbit ? SS_W'(trial - {1'b0, divisor}) : trial[SS_W-1:0];
        mod_dbl  = {mod_reg, qbit};
        mod_next = (mod_dbl >= modulus) ? SRV_W'(mod_dbl - modulus) : mod_dbl[SRV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (dctl.start)
        begin
            count_reg <= DCNT_W'(DIV_STEPS - 1);
        end
        else if (dctl.step && count_reg != '0)
        begin
            count_reg <= count_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (dctl.start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            mod_reg <= '0;
        end
        else if (dctl.step)
        begin
            dvd_reg <= {dvd_reg[OFF_W-2:0], 1'b0};
            rem_reg <= rem_next;
            mod_reg <= mod_next;
        end
    end

    assign remainder = rem_reg;
    assign quo_mod   = mod_reg;
    assign busy      = count_reg != '0;

endmodule

@@ design/srs_checker.sv @@
module srs_checker import srs_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       status,
    input logic             last_chunk,
    input logic [LEN_W-1:0] chunk_bytes
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("chunk word dropped while stalled");

    a_one_region: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("region accepted while another is in work");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> last_chunk && chunk_bytes == '0)
        else $error("error word not final or not empty");

    a_mid_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_chunk |-> status == ST_OK && chunk_bytes != '0)
        else $error("non-final chunk with error or zero length");

endmodule

bind stripe_region_splitter_core srs_checker u_srs_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (region.valid),
    .in_ready    (region.ready),
    .out_valid   (chunk.valid),
    .out_ready   (chunk.ready),
    .status      (chunk.status),
    .last_chunk  (chunk.last_chunk),
    .chunk_bytes (chunk.chunk_bytes)
);

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import srs_pkg::*;

    // One chunk word as the block should present it on the chunk channel.
    typedef struct {
        logic [SRV_W-1:0] server_index;
        logic [LEN_W-1:0] chunk_bytes;
        logic [LEN_W-1:0] buffer_offset;
        logic             chunk_kind;
        logic [1:0]       status;
        logic             last_chunk;
    } chunk_word_t;

    // Rows of the directed part: a register write, a region whose chunks are
    // worked out by the predictor, or a region whose answer is written out here.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_TYPED
    } row_kind_t;

    typedef struct {
        row_kind_t        kind;
        logic [IDX_W-1:0] reg_index;
        logic [CFG_W-1:0] reg_data;
        logic [OFF_W-1:0] offset;
        logic [LEN_W-1:0] nbytes;
        logic             access;
        int               typed_count;
        chunk_word_t      typed_word;
    } stim_row_t;

    // Index 3 is not a register; a write there must leave the settings alone.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [63:0] MAX_OFFSET = 64'h0000_FFFF_FFFF_FFFF;
    localparam logic [63:0] MAX_LENGTH = 64'h0000_0000_FFFF_FFFF;
    // Cycles allowed after the last expected word before the block counts as idle:
    // an empty region gives no word but still takes the sequencer through its load and setup steps.
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES = 200;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 35;

    logic clk;
    logic rst_n;

    srs_region_if region_ch ();
    srs_chunk_if  chunk_ch ();
    srs_cfg_if    cfg_ch ();

    stripe_region_splitter_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .region (region_ch),
        .chunk  (chunk_ch),
        .cfg    (cfg_ch)
    );

    // The settings as the predictor believes them to be, starting from the
    // reset defaults of the block.
    logic [SS_W-1:0]  cur_stripe_bytes = STRIPE_BYTES_RST;
    logic [OFF_W-1:0] cur_origin       = STRIPE_ORIGIN_RST;
    logic [CNT_W-1:0] cur_servers      = SERVER_COUNT_RST;

    chunk_word_t expected_chunks[$];
    stim_row_t   directed_rows[$];
    int          error_count = 0;
    // When set, neither side idles: this is the last part of the run.
    bit          calm = 1'b0;
    int          gap_odds = 3;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // A stripe size of zero behaves as one byte.
    function automatic logic [63:0] eff_stripe();
        return (cur_stripe_bytes == '0) ? 64'd1 : 64'(cur_stripe_bytes);
    endfunction

    // A server count of zero behaves as one; anything above 256 saturates.
    function automatic logic [63:0] eff_servers();
        if (cur_servers == '0)
            return 64'd1;
        if (cur_servers > SERVER_COUNT_MAX)
            return 64'(SERVER_COUNT_MAX);
        return 64'(cur_servers);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic chunk_word_t make_word(logic [63:0] srv, logic [63:0] len,
                                              logic [63:0] boff, logic kind,
                                              status_t st, logic last);
        chunk_word_t w;
        w.server_index  = srv[SRV_W-1:0];
        w.chunk_bytes   = len[LEN_W-1:0];
        w.buffer_offset = boff[LEN_W-1:0];
        w.chunk_kind    = kind;
        w.status        = st;
        w.last_chunk    = last;
        return w;
    endfunction

    // Splits one region into its stripe pieces and queues the words that the
    // block should give for it, under the current settings.
    function automatic void predict_chunks(logic [OFF_W-1:0] off, logic [LEN_W-1:0] nbytes,
                                           logic kind);
        logic [63:0] ss;
        logic [63:0] cnt;
        logic [63:0] len;
        logic [63:0] rel;
        logic [63:0] srv;
        logic [63:0] first;
        logic [63:0] pieces;
        logic [63:0] done;
        logic [63:0] piece;
        logic [63:0] left;
        logic [63:0] k;
        ss  = eff_stripe();
        cnt = eff_servers();
        len = 64'(nbytes);
        if (len == 0)
            return;
        if (cnt == 1) begin
            expected_chunks.push_back(make_word(0, len, 0, kind, ST_OK, 1'b1));
            return;
        end
        if (off < cur_origin) begin
            expected_chunks.push_back(make_word(0, 0, 0, kind, ST_BELOW, 1'b1));
            return;
        end
        rel   = 64'(off) - 64'(cur_origin);
        srv   = (rel / ss) % cnt;
        first = ss - (rel % ss);
        if (len <= first)
            pieces = 1;
        else
            pieces = 1 + (len - first + ss - 1) / ss;
        if (pieces > MAX_CHUNKS_DEF) begin
            expected_chunks.push_back(make_word(0, 0, 0, kind, ST_MANY, 1'b1));
            return;
        end
        done  = 0;
        piece = first;
        for (k = 0; k < pieces; k++) begin
            left = len - done;
            if (piece > left)
                piece = left;
            expected_chunks.push_back(make_word(srv, piece, done, kind, ST_OK,
                                                (k + 1 == pieces)));
            done  = done + piece;
            piece = ss;
            srv   = (srv + 1) % cnt;
        end
    endfunction

    task automatic add_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        stim_row_t r;
        r = '{kind: ROW_CFG, reg_index: idx, reg_data: data, default: '0};
        directed_rows.push_back(r);
    endtask

    task automatic add_region(logic [OFF_W-1:0] off, logic [LEN_W-1:0] nbytes, logic kind);
        stim_row_t r;
        r = '{kind: ROW_PREDICT, offset: off, nbytes: nbytes, access: kind, default: '0};
        directed_rows.push_back(r);
    endtask

    // A region whose answer is plain to see: nothing, or one word on server 0 at
    // buffer offset 0 carrying the given length and status.
    task automatic add_typed(logic [OFF_W-1:0] off, logic [LEN_W-1:0] nbytes, logic kind,
                             int count, status_t st, logic [LEN_W-1:0] len);
        stim_row_t r;
        r = '{kind: ROW_TYPED, offset: off, nbytes: nbytes, access: kind, default: '0};
        r.typed_count = count;
        r.typed_word  = make_word(0, 64'(len), 0, kind, st, 1'b1);
        directed_rows.push_back(r);
    endtask

    // Register writes wait for the block to fall idle. The region valid is
    // dropped here, so callers come straight from an accepted word or a gap.
    task automatic write_register(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        region_ch.valid <= 1'b0;
        wait (expected_chunks.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_STRIPE_BYTES)
            cur_stripe_bytes = data[SS_W-1:0];
        else if (idx == REG_STRIPE_ORIGIN)
            cur_origin = data[OFF_W-1:0];
        else if (idx == REG_SERVER_COUNT)
            cur_servers = data[CNT_W-1:0];
    endtask

    // Presents one region word and holds it until it is taken. The valid is
    // left high, so a following word goes out on the next cycle with no bubble.
    // The expectation is queued at the edge of acceptance, under the settings
    // that hold at that moment.
    task automatic send_region(logic [OFF_W-1:0] off, logic [LEN_W-1:0] nbytes, logic kind,
                               bit typed, int typed_count, chunk_word_t typed_word);
        region_ch.valid         <= 1'b1;
        region_ch.region_offset <= off;
        region_ch.region_bytes  <= nbytes;
        region_ch.access_kind   <= kind;
        do
            @(posedge clk);
        while (!region_ch.ready);
        if (!typed)
            predict_chunks(off, nbytes, kind);
        else if (typed_count > 0)
            expected_chunks.push_back(typed_word);
    endtask

    // A random burst of idle cycles on the sending side, unless the run is calm or the gap odds are zero.
    task automatic sender_gap();
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds) == 0) begin
            region_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    // Draws a fresh setting for every register, leaning towards small stripes
    // and a handful of servers so that regions break into many pieces, but
    // reaching the extremes too. Bits above a register's width are junk.
    task automatic pick_settings();
        logic [CFG_W-1:0] data;
        int unsigned      pick;
        pick = $urandom_range(0, 9);
        data = CFG_W'(rand64());
        if (pick < 4)
            data[SS_W-1:0] = SS_W'($urandom_range(1, 16));
        else if (pick < 6)
            data[SS_W-1:0] = SS_W'($urandom_range(17, 4096));
        else if (pick == 6)
            data[SS_W-1:0] = '0;
        else if (pick == 7)
            data[SS_W-1:0] = '1;
        write_register(REG_STRIPE_BYTES, data);

        pick = $urandom_range(0, 9);
        if (pick < 5)
            data = CFG_W'($urandom_range(0, 1000));
        else if (pick < 8)
            data = CFG_W'(rand64());
        else
            data = '0;
        write_register(REG_STRIPE_ORIGIN, data);

        pick = $urandom_range(0, 19);
        data = CFG_W'(rand64());
        if (pick < 10)
            data[CNT_W-1:0] = CNT_W'($urandom_range(2, 8));
        else if (pick < 13)
            data[CNT_W-1:0] = CNT_W'($urandom_range(9, 255));
        else if (pick < 15)
            data[CNT_W-1:0] = SERVER_COUNT_MAX;
        else if (pick < 17)
            data[CNT_W-1:0] = CNT_W'(1);
        else if (pick == 17)
            data[CNT_W-1:0] = '0;
        else
            data[CNT_W-1:0] = CNT_W'($urandom_range(257, 511));
        write_register(REG_SERVER_COUNT, data);
    endtask

    // Mostly well-formed regions: at or above the origin and short enough to
    // stay within the chunk limit. The rest are empty regions, regions below
    // the origin, regions far too long, and offsets taken at random.
    task automatic make_region(output logic [OFF_W-1:0] off, output logic [LEN_W-1:0] nbytes,
                               output logic kind);
        logic [63:0] ss;
        logic [63:0] cnt;
        logic [63:0] rel_max;
        logic [63:0] rel;
        logic [63:0] span;
        logic [63:0] lim;
        int unsigned pick;
        ss      = eff_stripe();
        cnt     = eff_servers();
        rel_max = MAX_OFFSET - 64'(cur_origin);
        kind    = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) begin
            span = ss * cnt * 4;
            rel  = (span > rel_max) ? rand64() % (rel_max + 1) : rand64() % span;
        end
        else begin
            rel = rand64() % (rel_max + 1);
        end
        off = OFF_W'(64'(cur_origin) + rel);
        lim = ($urandom_range(0, 9) < 6) ? ss * 4 : ss * 63 + 1;
        if (lim > MAX_LENGTH)
            lim = MAX_LENGTH;
        nbytes = LEN_W'(rand64() % lim + 1);
        pick = $urandom_range(0, 11);
        case (pick)
            0: nbytes = '0;
            1: if (cur_origin != '0) off = OFF_W'(rand64() % 64'(cur_origin));
            2: nbytes = $urandom;
            3: off = OFF_W'(rand64());
            default: ;
        endcase
    endtask

    // Result side: the ready idles in random bursts, with long runs
    // of steady readiness in between, and stays high once the run is calm.
    initial
    begin
        forever
        begin
            int unsigned pick;
            pick = $urandom_range(0, 7);
            if (calm || pick > 2) begin
                chunk_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else if (pick == 2) begin
                chunk_ch.ready <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else begin
                chunk_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge clk);
            end
        end
    end

    // Every chunk word taken is held against the oldest expectation, field by
    // field. Values read here are those that stood at the clock edge.
    always @(posedge clk)
    begin : chunk_check
        chunk_word_t want;
        if (rst_n && chunk_ch.valid && chunk_ch.ready) begin
            if (expected_chunks.size() == 0) begin
                $error("unexpected chunk word: server %0d, bytes %0d, status %0d",
                       chunk_ch.server_index, chunk_ch.chunk_bytes, chunk_ch.status);
                error_count++;
            end
            else begin
                want = expected_chunks.pop_front();
                if (chunk_ch.server_index !== want.server_index) begin
                    $error("server_index: expected %0d, got %0d",
                           want.server_index, chunk_ch.server_index);
                    error_count++;
                end
                if (chunk_ch.chunk_bytes !== want.chunk_bytes) begin
                    $error("chunk_bytes: expected %0d, got %0d",
                           want.chunk_bytes, chunk_ch.chunk_bytes);
                    error_count++;
                end
                if (chunk_ch.buffer_offset !== want.buffer_offset) begin
                    $error("buffer_offset: expected %0d, got %0d",
                           want.buffer_offset, chunk_ch.buffer_offset);
                    error_count++;
                end
                if (chunk_ch.chunk_kind !== want.chunk_kind) begin
                    $error("chunk_kind: expected %0d, got %0d",
                           want.chunk_kind, chunk_ch.chunk_kind);
                    error_count++;
                end
                if (chunk_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, chunk_ch.status);
                    error_count++;
                end
                if (chunk_ch.last_chunk !== want.last_chunk) begin
                    $error("last_chunk: expected %0d, got %0d",
                           want.last_chunk, chunk_ch.last_chunk);
                    error_count++;
                end
            end
        end
    end

    // The slowest correct run, with every region at 64 pieces each waiting out
    // a full stall, stays well below this bound.
    initial
    begin
        #8_000_000;
        $display("tb: done, errors");
        $finish;
    end

    initial
    begin
        logic [OFF_W-1:0] off;
        logic [LEN_W-1:0] nbytes;
        logic             kind;
        chunk_word_t      none;

        none = make_word(0, 0, 0, 1'b0, ST_OK, 1'b0);
        rst_n                   <= 1'b0;
        region_ch.valid         <= 1'b0;
        region_ch.region_offset <= '0;
        region_ch.region_bytes  <= '0;
        region_ch.access_kind   <= 1'b0;
        cfg_ch.valid            <= 1'b0;
        cfg_ch.index            <= REG_STRIPE_BYTES;
        cfg_ch.data             <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: a single server, so each non-empty region is one whole chunk,
        // even at the largest offset and length.
        add_typed(48'd0, 32'd100, 1'b0, 1, ST_OK, 32'd100);
        add_typed(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1, ST_OK, 32'hFFFF_FFFF);
        add_typed(48'd5, 32'd0, 1'b0, 0, ST_OK, 32'd0);
        // Four servers of 16 byte stripes from offset 1000.
        add_cfg(REG_SERVER_COUNT, 48'd4);
        add_cfg(REG_STRIPE_BYTES, 48'd16);
        add_cfg(REG_STRIPE_ORIGIN, 48'd1000);
        add_typed(48'd999, 32'd10, 1'b1, 1, ST_BELOW, 32'd0);
        // An empty region gives nothing even where it would be an error.
        add_typed(48'd999, 32'd0, 1'b1, 0, ST_OK, 32'd0);
        // Exactly the chunk limit, then one byte past it.
        add_region(48'd1000, 32'd1024, 1'b0);
        add_typed(48'd1000, 32'd1025, 1'b0, 1, ST_MANY, 32'd0);
        add_cfg(REG_UNUSED, 48'h0000_1234_5678);
        add_region(48'd1005, 32'd20, 1'b1);
        // A region that fills out the rest of its first stripe exactly.
        add_region(48'd1197, 32'd11, 1'b0);
        add_typed(48'd0, 32'd1, 1'b1, 1, ST_BELOW, 32'd0);
        // Zero stripe size acts as one byte; 256 servers wrap round to server 0.
        add_cfg(REG_STRIPE_BYTES, 48'd0);
        add_cfg(REG_SERVER_COUNT, 48'd256);
        add_cfg(REG_STRIPE_ORIGIN, 48'd0);
        add_region(48'd255, 32'd64, 1'b0);
        add_typed(48'd0, 32'd65, 1'b1, 1, ST_MANY, 32'd0);
        add_region(48'hFFFF_FFFF_FFFF, 32'd3, 1'b1);
        // Zero servers act as one.
        add_cfg(REG_SERVER_COUNT, 48'd0);
        add_typed(48'd7, 32'd12, 1'b1, 1, ST_OK, 32'd12);
        // Every register at its top value; the server count saturates at 256.
        add_cfg(REG_SERVER_COUNT, 48'd511);
        add_cfg(REG_STRIPE_BYTES, 48'hFFFF_FFFF);
        add_cfg(REG_STRIPE_ORIGIN, 48'hFFFF_FFFF_FFFF);
        add_region(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        add_typed(48'hFFFF_FFFF_FFFE, 32'd5, 1'b0, 1, ST_BELOW, 32'd0);
        add_cfg(REG_STRIPE_ORIGIN, 48'd0);
        add_cfg(REG_SERVER_COUNT, 48'd2);
        add_cfg(REG_STRIPE_BYTES, 48'd1);
        add_region(48'h8000_0000_0001, 32'd64, 1'b1);
        add_typed(48'd3, 32'h8000_0000, 1'b0, 1, ST_MANY, 32'd0);

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_register(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else begin
                send_region(directed_rows[i].offset, directed_rows[i].nbytes,
                            directed_rows[i].access, directed_rows[i].kind == ROW_TYPED,
                            directed_rows[i].typed_count,
                            (directed_rows[i].kind == ROW_TYPED) ?
                                directed_rows[i].typed_word : none);
                sender_gap();
            end
        end

        // Random phases, each under fresh settings. The last phase runs calm.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            calm     = (phase == RANDOM_PHASES - 1);
            gap_odds = (phase % 2 == 1) ? 0 : 3;
            pick_settings();
            for (int item = 0; item < ITEMS_PER_PHASE; item++) begin
                make_region(off, nbytes, kind);
                send_region(off, nbytes, kind, 1'b0, 0, none);
                if (phase == 2 && item == ITEMS_PER_PHASE / 2) begin
                    // Hold the sender back until the block has answered everything.
                    region_ch.valid <= 1'b0;
                    wait (expected_chunks.size() == 0);
                    @(posedge clk);
                end
                else begin
                    sender_gap();
                end
            end
        end

        region_ch.valid <= 1'b0;
        wait (expected_chunks.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
